### sv/cccu_pkg.sv
// Shared types, codes and calendar helpers for the clock calendar counter.
package cccu_pkg;

    // Request command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_INC  = 2'd1;
    localparam logic [1:0] CMD_DEC  = 2'd2;

    // Adjustable field codes
    localparam logic [2:0] FLD_HOUR    = 3'd0;
    localparam logic [2:0] FLD_MINUTE  = 3'd1;
    localparam logic [2:0] FLD_DAY     = 3'd2;
    localparam logic [2:0] FLD_MONTH   = 3'd3;
    localparam logic [2:0] FLD_YEAR    = 3'd4;
    localparam logic [2:0] FLD_WEEKDAY = 3'd5;

    // Field limits
    localparam logic [5:0]  SEC_MAX   = 6'd59;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [2:0]  WDAY_MAX  = 3'd6;

    // Register map
    localparam logic [0:0] REG_TICKS_PER_SECOND = 1'b0;
    localparam logic [7:0] TPS_RESET            = 8'd5;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  weekday;
    } t_cal;

    localparam t_cal CAL_RESET = '{
        second:  6'd0,
        minute:  6'd20,
        hour:    5'd9,
        day:     5'd24,
        month:   4'd4,
        year:    14'd2023,
        weekday: 3'd0
    };

    // Days in a month; every fourth year is a leap year
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic [13:0] year);
        logic [4:0] len;
        len = 5'd31;
        unique case (month)
            4'd2:                      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### sv/clock_calendar_counter_unit.sv
// Top level of the clock calendar counter: config register, state and output skid.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  request   | i_valid / o_stall  | i_command, i_field_select
//  result    | o_valid / i_stall  | o_seconds .. o_weekday (time after the request)
//  config    | APB psel/penable   | ticks_per_second at byte address 0
//
//  One request is accepted per cycle while o_stall is low; with room in the output
//  register, the result appears there in the cycle after the accept, else in the skid.
//  The calendar state is one register set updated in the accept cycle, so the
//  next request sees it at once; the carry chain is a single pass of logic.
//  A two-entry output (main register plus skid) lets a request be accepted
//  while a result is stalled; o_stall rises only when both entries hold data.
//  Synchronous active-low reset loads CAL_RESET (09:20:00, Monday) and
//  ticks_per_second = 5; no clearing pass is needed.
module clock_calendar_counter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_field_select,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_seconds,
    output logic [5:0]  o_minutes,
    output logic [4:0]  o_hours,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_number,
    output logic [13:0] o_year_number,
    output logic [2:0]  o_weekday,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cccu_pkg::*;

    logic [7:0] r_tps;
    logic [7:0] r_tick;
    t_cal       r_cal;
    t_cal       r_out;
    t_cal       r_skid;
    logic       r_out_valid;
    logic       r_skid_valid;

    t_cal       n_cal;
    logic [7:0] n_tick;

    logic       w_accept;
    logic       w_out_free;
    logic       w_cfg_wr;

    // Configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_TICKS_PER_SECOND) ? {24'd0, r_tps} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_TICKS_PER_SECOND)) begin
            r_tps <= pwdata[7:0];
        end
    end

    // Next calendar state for the request at the port
    cccu_step u_step (
        .i_cal              (r_cal),
        .i_tick_count       (r_tick),
        .i_ticks_per_second (r_tps),
        .i_command          (i_command),
        .i_field_select     (i_field_select),
        .o_cal              (n_cal),
        .o_tick_count       (n_tick)
    );

    // Hold requests off only when the skid entry is occupied
    assign o_stall    = r_skid_valid;
    assign w_accept   = i_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_stall;

    // Advance the clock state on every accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal  <= CAL_RESET;
            r_tick <= 8'd0;
        end else if (w_accept) begin
            r_cal  <= n_cal;
            r_tick <= n_tick;
        end
    end

    // Output register and skid entry: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid  <= r_skid_valid || w_accept;
                r_skid_valid <= 1'b0;
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Output register and skid entry: payload
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : n_cal;
        end
        if (w_accept && !w_out_free) begin
            r_skid <= n_cal;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_seconds      = r_out.second;
    assign o_minutes      = r_out.minute;
    assign o_hours        = r_out.hour;
    assign o_day_of_month = r_out.day;
    assign o_month_number = r_out.month;
    assign o_year_number  = r_out.year;
    assign o_weekday      = r_out.weekday;

    // The skid entry only fills behind a stalled output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // An accepted request with room in the output register shows up next cycle
    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_out_free) |=> (r_out_valid && (r_out == $past(n_cal))))
        else $error("accepted request did not reach the output register");

    // The calendar state moves only on an accepted request
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_accept) |=> ($stable(r_cal) && $stable(r_tick)))
        else $error("calendar state changed without a request");

    // Every field stays within its range
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cal.second <= SEC_MAX) && (r_cal.minute <= MIN_MAX) && (r_cal.hour <= HOUR_MAX)
        && (r_cal.month >= 4'd1) && (r_cal.month <= MONTH_MAX) && (r_cal.year <= YEAR_MAX)
        && (r_cal.weekday <= WDAY_MAX) && (r_cal.day >= 5'd1)
        && (r_cal.day <= month_len(r_cal.month, r_cal.year)))
        else $error("calendar field out of range");

endmodule

### sv/cccu_step.sv
// Next-state logic of the calendar: tick carry chain and field adjustment.
module cccu_step (
    input  cccu_pkg::t_cal  i_cal,
    input  logic [7:0]      i_tick_count,
    input  logic [7:0]      i_ticks_per_second,
    input  logic [1:0]      i_command,
    input  logic [2:0]      i_field_select,
    output cccu_pkg::t_cal  o_cal,
    output logic [7:0]      o_tick_count
);
    import cccu_pkg::*;

    logic [8:0] w_tick_inc;
    logic       w_sec_evt;
    logic       w_min_evt;
    logic       w_hour_evt;
    logic       w_day_evt;
    logic       w_month_evt;
    logic       w_year_evt;
    logic [4:0] w_len;
    logic       w_up;

    assign w_tick_inc  = {1'b0, i_tick_count} + 9'd1;
    assign w_sec_evt   = (w_tick_inc >= {1'b0, i_ticks_per_second});
    assign w_min_evt   = w_sec_evt  && (i_cal.second >= SEC_MAX);
    assign w_hour_evt  = w_min_evt  && (i_cal.minute >= MIN_MAX);
    assign w_day_evt   = w_hour_evt && (i_cal.hour >= HOUR_MAX);
    assign w_len       = month_len(i_cal.month, i_cal.year);
    assign w_month_evt = w_day_evt   && (i_cal.day >= w_len);
    assign w_year_evt  = w_month_evt && (i_cal.month >= MONTH_MAX);
    assign w_up        = (i_command == CMD_INC);

    always_comb begin
        o_cal        = i_cal;
        o_tick_count = i_tick_count;
        unique case (i_command)
            CMD_TICK: begin
                o_tick_count = w_sec_evt ? 8'd0 : w_tick_inc[7:0];
                if (w_sec_evt) begin
                    o_cal.second = (i_cal.second >= SEC_MAX) ? 6'd0 : i_cal.second + 6'd1;
                end
                if (w_min_evt) begin
                    o_cal.minute = (i_cal.minute >= MIN_MAX) ? 6'd0 : i_cal.minute + 6'd1;
                end
                if (w_hour_evt) begin
                    o_cal.hour = (i_cal.hour >= HOUR_MAX) ? 5'd0 : i_cal.hour + 5'd1;
                end
                if (w_day_evt) begin
                    o_cal.weekday = (i_cal.weekday >= WDAY_MAX) ? 3'd0 : i_cal.weekday + 3'd1;
                    o_cal.day     = (i_cal.day < w_len) ? i_cal.day + 5'd1 : 5'd1;
                end
                if (w_month_evt) begin
                    o_cal.month = (i_cal.month < MONTH_MAX) ? i_cal.month + 4'd1 : 4'd1;
                end
                if (w_year_evt) begin
                    o_cal.year = (i_cal.year >= YEAR_MAX) ? 14'd0 : i_cal.year + 14'd1;
                end
            end
            CMD_INC, CMD_DEC: begin
                unique case (i_field_select)
                    FLD_HOUR: begin
                        if (w_up) o_cal.hour = (i_cal.hour >= HOUR_MAX) ? 5'd0 : i_cal.hour + 5'd1;
                        else      o_cal.hour = (i_cal.hour == 5'd0) ? HOUR_MAX : i_cal.hour - 5'd1;
                    end
                    FLD_MINUTE: begin
                        if (w_up) o_cal.minute = (i_cal.minute >= MIN_MAX) ? 6'd0
                                                                         : i_cal.minute + 6'd1;
                        else      o_cal.minute = (i_cal.minute == 6'd0) ? MIN_MAX
                                                                      : i_cal.minute - 6'd1;
                    end
                    FLD_DAY: begin
                        if (w_up) o_cal.day = (i_cal.day >= w_len) ? 5'd1 : i_cal.day + 5'd1;
                        else      o_cal.day = (i_cal.day <= 5'd1) ? w_len : i_cal.day - 5'd1;
                    end
                    FLD_MONTH: begin
                        if (w_up) o_cal.month = (i_cal.month >= MONTH_MAX) ? 4'd1
                                                                         : i_cal.month + 4'd1;
                        else      o_cal.month = (i_cal.month <= 4'd1) ? MONTH_MAX
                                                                      : i_cal.month - 4'd1;
                    end
                    FLD_YEAR: begin
                        if (w_up) o_cal.year = (i_cal.year >= YEAR_MAX) ? 14'd0
                                                                       : i_cal.year + 14'd1;
                        else      o_cal.year = (i_cal.year == 14'd0) ? YEAR_MAX
                                                                    : i_cal.year - 14'd1;
                    end
                    FLD_WEEKDAY: begin
                        if (w_up) o_cal.weekday = (i_cal.weekday >= WDAY_MAX) ? 3'd0
                                                                             : i_cal.weekday + 3'd1;
                        else      o_cal.weekday = (i_cal.weekday == 3'd0) ? WDAY_MAX
                                                                         : i_cal.weekday - 3'd1;
                    end
                    default: ;
                endcase
                // Drop the day back to 1 when it no longer fits the month
                if (o_cal.day > month_len(o_cal.month, o_cal.year)) begin
                    o_cal.day = 5'd1;
                end
            end
            default: ;
        endcase
    end

endmodule

### test/tb_clock_calendar_counter_unit.sv
// Self-checking testbench for the clock calendar counter: directed and random requests.
module tb_clock_calendar_counter_unit;
    import cccu_pkg::*;

    // Codes the package leaves unnamed: the spare command and the spare field selects
    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam logic [2:0] FLD_SPARE_A = 3'd6;
    localparam logic [2:0] FLD_SPARE_B = 3'd7;
    localparam logic [2:0] TPS_ADDR    = {REG_TICKS_PER_SECOND, 2'b00};

    typedef struct packed {
        logic [7:0] ticks;
        t_cal       cal;
    } t_rtc_state;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] sel;
    } t_rtc_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = CMD_TICK;
    logic [2:0]  i_field_select = FLD_HOUR;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [5:0]  o_seconds;
    logic [5:0]  o_minutes;
    logic [4:0]  o_hours;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month_number;
    logic [13:0] o_year_number;
    logic [2:0]  o_weekday;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Requests waiting to be sent, and the clock readings they must produce
    t_rtc_req   request_queue[$];
    t_cal       due_times[$];

    // Planning copy of the clock: tracks where queued requests will leave it
    t_rtc_state plan;
    logic [7:0] plan_tps;
    // Live copy of the clock: advanced as the block accepts requests
    t_rtc_state clock_now;
    logic [7:0] tps_now;

    int queued_n = 0;
    int checked_n = 0;
    int phase_n = 0;
    int mismatches = 0;
    int settings_n = 0;
    int day_turns = 0;
    int send_gap = 0;
    int send_calm = 0;
    int stall_left = 0;
    int stall_calm = 0;

    clock_calendar_counter_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_field_select (i_field_select),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_seconds      (o_seconds),
        .o_minutes      (o_minutes),
        .o_hours        (o_hours),
        .o_day_of_month (o_day_of_month),
        .o_month_number (o_month_number),
        .o_year_number  (o_year_number),
        .o_weekday      (o_weekday),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------
    function automatic int days_in_month(input int month, input int year);
        if (month == 2) return (year % 4 == 0) ? 29 : 28;
        if (month == 4 || month == 6 || month == 9 || month == 11) return 30;
        return 31;
    endfunction

    function automatic int bump_up(input int v, input int lo, input int hi);
        return (v >= hi) ? lo : v + 1;
    endfunction

    function automatic int bump_down(input int v, input int lo, input int hi);
        return (v <= lo) ? hi : v - 1;
    endfunction

    // Next clock state after one request
    function automatic t_rtc_state calendar_next(input t_rtc_state s, input logic [7:0] tps,
                                                 input logic [1:0] cmd, input logic [2:0] sel);
        t_rtc_state n;
        logic       carry;
        logic       up;
        int         len;
        n  = s;
        up = (cmd == CMD_INC);
        if (cmd == CMD_TICK) begin
            // Count toward one second; a rate of zero acts as one
            if (int'(n.ticks) + 1 < int'(tps)) begin
                n.ticks = n.ticks + 8'd1;
                return n;
            end
            n.ticks      = '0;
            n.cal.second = 6'(bump_up(n.cal.second, 0, SEC_MAX));
            carry        = (n.cal.second == 6'd0);
            if (carry) begin
                n.cal.minute = 6'(bump_up(n.cal.minute, 0, MIN_MAX));
                carry        = (n.cal.minute == 6'd0);
            end
            if (carry) begin
                n.cal.hour = 5'(bump_up(n.cal.hour, 0, HOUR_MAX));
                carry      = (n.cal.hour == 5'd0);
            end
            if (carry) begin
                // Midnight: advance weekday and date, rippling into month and year
                n.cal.weekday = 3'(bump_up(n.cal.weekday, 0, WDAY_MAX));
                if (n.cal.day < days_in_month(n.cal.month, n.cal.year)) begin
                    n.cal.day = n.cal.day + 5'd1;
                end else begin
                    n.cal.day = 5'd1;
                    if (n.cal.month < MONTH_MAX) begin
                        n.cal.month = n.cal.month + 4'd1;
                    end else begin
                        n.cal.month = 4'd1;
                        n.cal.year  = 14'(bump_up(n.cal.year, 0, YEAR_MAX));
                    end
                end
            end
        end else if (cmd == CMD_INC || cmd == CMD_DEC) begin
            len = days_in_month(n.cal.month, n.cal.year);
            case (sel)
                FLD_HOUR: begin
                    n.cal.hour = 5'(up ? bump_up(n.cal.hour, 0, HOUR_MAX)
                                       : bump_down(n.cal.hour, 0, HOUR_MAX));
                end
                FLD_MINUTE: begin
                    n.cal.minute = 6'(up ? bump_up(n.cal.minute, 0, MIN_MAX)
                                         : bump_down(n.cal.minute, 0, MIN_MAX));
                end
                FLD_DAY: begin
                    n.cal.day = 5'(up ? bump_up(n.cal.day, 1, len) : bump_down(n.cal.day, 1, len));
                end
                FLD_MONTH: begin
                    n.cal.month = 4'(up ? bump_up(n.cal.month, 1, MONTH_MAX)
                                        : bump_down(n.cal.month, 1, MONTH_MAX));
                end
                FLD_YEAR: begin
                    n.cal.year = 14'(up ? bump_up(n.cal.year, 0, YEAR_MAX)
                                        : bump_down(n.cal.year, 0, YEAR_MAX));
                end
                FLD_WEEKDAY: begin
                    n.cal.weekday = 3'(up ? bump_up(n.cal.weekday, 0, WDAY_MAX)
                                          : bump_down(n.cal.weekday, 0, WDAY_MAX));
                end
                default: begin
                end
            endcase
            // Drop the day back to the first when the month got shorter
            if (n.cal.day > days_in_month(n.cal.month, n.cal.year)) n.cal.day = 5'd1;
        end
        return n;
    endfunction

    function automatic string show(input t_cal c);
        return $sformatf("%02d:%02d:%02d day %0d month %0d year %0d weekday %0d",
                         c.hour, c.minute, c.second, c.day, c.month, c.year, c.weekday);
    endfunction

    // Mostly no idling, sometimes short gaps, rarely long ones, and calm stretches
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------
    function automatic void queue_request(input logic [1:0] cmd, input logic [2:0] sel);
        t_rtc_req r;
        r.cmd = cmd;
        r.sel = sel;
        request_queue.push_back(r);
        plan = calendar_next(plan, plan_tps, cmd, sel);
        queued_n++;
        phase_n++;
    endfunction

    function automatic void random_request();
        int         r;
        logic [1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 40)      cmd = CMD_TICK;
        else if (r < 65) cmd = CMD_INC;
        else if (r < 90) cmd = CMD_DEC;
        else             cmd = CMD_NONE;
        queue_request(cmd, 3'($urandom_range(0, 7)));
    endfunction

    // Walk one field to a target by the shorter way around its range
    task automatic steer_field(input logic [2:0] sel, input int target);
        int lo;
        int hi;
        int cur;
        int span;
        int ups;
        int downs;
        lo = 0;
        case (sel)
            FLD_HOUR:    begin hi = HOUR_MAX;  cur = plan.cal.hour;    end
            FLD_MINUTE:  begin hi = MIN_MAX;   cur = plan.cal.minute;  end
            FLD_DAY: begin
                lo  = 1;
                hi  = days_in_month(plan.cal.month, plan.cal.year);
                cur = plan.cal.day;
            end
            FLD_MONTH:   begin lo = 1; hi = MONTH_MAX; cur = plan.cal.month; end
            FLD_YEAR:    begin hi = YEAR_MAX;  cur = plan.cal.year;    end
            default:     begin hi = WDAY_MAX;  cur = plan.cal.weekday; end
        endcase
        span  = hi - lo + 1;
        ups   = ((target - cur) % span + span) % span;
        downs = (span - ups) % span;
        if (ups <= downs) repeat (ups) queue_request(CMD_INC, sel);
        else              repeat (downs) queue_request(CMD_DEC, sel);
    endtask

    // Set the clock to 23:59 on a chosen date, then tick across midnight
    task automatic day_end_run(input int month_pick, input bit to_month_end, input bit shift_year);
        int start;
        int guard;
        steer_field(FLD_MONTH, (month_pick == 0) ? $urandom_range(1, MONTH_MAX) : month_pick);
        if (shift_year) steer_field(FLD_YEAR, (int'(plan.cal.year) + $urandom_range(0, 3)) % 10000);
        if (to_month_end) steer_field(FLD_DAY, days_in_month(plan.cal.month, plan.cal.year));
        steer_field(FLD_HOUR, HOUR_MAX);
        steer_field(FLD_MINUTE, MIN_MAX);
        start = plan.cal.minute;
        guard = 0;
        while (plan.cal.minute == start && guard < 61 * 256) begin
            queue_request(CMD_TICK, 3'($urandom_range(0, 7)));
            guard++;
        end
    endtask

    // Park the day near the month end, then move month or year to force a clamp
    task automatic clamp_run();
        int len;
        len = days_in_month(plan.cal.month, plan.cal.year);
        steer_field(FLD_DAY, $urandom_range(28, len));
        repeat ($urandom_range(1, 4)) begin
            queue_request($urandom_range(0, 1) ? CMD_INC : CMD_DEC,
                          $urandom_range(0, 1) ? FLD_MONTH : FLD_YEAR);
        end
    endtask

    task automatic random_phase(input int budget, input bit long_runs);
        int pick;
        phase_n = 0;
        while (phase_n < budget) begin
            pick = $urandom_range(0, 99);
            if (long_runs && pick < 25) day_end_run(0, $urandom_range(0, 1), 1'b1);
            else if (pick < 40)         clamp_run();
            else                        repeat ($urandom_range(1, 8)) random_request();
        end
    endtask

    // Hold until every queued request has produced its checked result
    task automatic wait_idle();
        while (checked_n != queued_n) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write the tick rate over APB, then read it back
    task automatic cfg_write(input logic [7:0] value);
        logic [31:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TPS_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // Write lands on this edge; keep the select and turn it into a read
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        tps_now  = value;
        plan_tps = value;
        settings_n++;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {24'd0, value}) begin
            if (mismatches < 10) $display("tick rate read-back: expected %0d, got %0h", value, rd);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: send queued requests, predict each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : request_drive
        t_rtc_req   nxt;
        t_rtc_state after;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            clock_now = '{ticks: 8'd0, cal: CAL_RESET};
            tps_now   = TPS_RESET;
        end else begin
            if (i_valid && !o_stall) begin
                after = calendar_next(clock_now, tps_now, i_command, i_field_select);
                if (i_command == CMD_TICK && after.cal.day != clock_now.cal.day) day_turns++;
                clock_now = after;
                due_times.push_back(after.cal);
            end
            // Advance to the next request only when the current one is gone
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    nxt = request_queue.pop_front();
                    i_valid        <= 1'b1;
                    i_command      <= nxt.cmd;
                    i_field_select <= nxt.sel;
                    send_gap = idle_len(send_calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: stall at random, compare every taken result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_cal got;
        t_cal want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{second: o_seconds, minute: o_minutes, hour: o_hours,
                        day: o_day_of_month, month: o_month_number,
                        year: o_year_number, weekday: o_weekday};
                if (due_times.size() == 0) begin
                    if (mismatches < 10) $display("result with none pending: %s", show(got));
                    mismatches++;
                end else begin
                    want = due_times.pop_front();
                    checked_n++;
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("result %0d mismatch at %0t", checked_n, $time);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                stall_left = idle_len(stall_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        plan     = '{ticks: 8'd0, cal: CAL_RESET};
        plan_tps = TPS_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one full second at the reset rate, spare codes, every field both ways
        repeat (5) queue_request(CMD_TICK, FLD_HOUR);
        queue_request(CMD_NONE, FLD_YEAR);
        queue_request(CMD_INC, FLD_SPARE_A);
        queue_request(CMD_DEC, FLD_SPARE_B);
        for (int f = FLD_HOUR; f <= FLD_WEEKDAY; f++) begin
            queue_request(CMD_DEC, 3'(f));
            queue_request(CMD_INC, 3'(f));
        end
        queue_request(CMD_DEC, FLD_WEEKDAY);
        queue_request(CMD_TICK, FLD_SPARE_B);
        wait_idle();

        // Fastest rate: midnight runs, month clamps, and one New Year rollover
        cfg_write(8'd1);
        random_phase(80, 1'b1);
        day_end_run(MONTH_MAX, 1'b1, 1'b0);
        wait_idle();

        // Slowest rate: enough ticks for one second, then adjustments
        cfg_write(8'd255);
        repeat (260) queue_request(CMD_TICK, 3'($urandom_range(0, 7)));
        random_phase(30, 1'b0);
        wait_idle();

        // Zero rate counts every tick as a second
        cfg_write(8'd0);
        random_phase(60, 1'b1);
        wait_idle();

        cfg_write(8'($urandom_range(2, 4)));
        random_phase(60, 1'b1);
        wait_idle();

        $display("Sent %0d requests across %0d tick-rate settings; %0d results checked.",
                 queued_n, settings_n, checked_n);
        $display("Ticks carried across midnight %0d times; %0d mismatches.",
                 day_turns, mismatches);
        if (mismatches == 0 && due_times.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Give up if the block stops answering
    initial begin
        #2000000;
        $display("Timeout with %0d of %0d results checked.", checked_n, queued_n);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
sv/cccu_pkg.sv
sv/cccu_step.sv
sv/clock_calendar_counter_unit.sv
test/tb_clock_calendar_counter_unit.sv
